@@ design/rpc_pkg.sv @@
// Shared constants, mode codes and stage control type for the pixel combine unit.
`timescale 1ns / 1ps

package rpc_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_OP_MODE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR = 8'd1;

  // Operation mode codes; the remaining codes pass the destination through
  localparam logic [2:0] MODE_FILL   = 3'd0;
  localparam logic [2:0] MODE_INVERT = 3'd1;
  localparam logic [2:0] MODE_GLYPH  = 3'd2;
  localparam logic [2:0] MODE_BLIT   = 3'd3;
  localparam logic [2:0] MODE_BLEND  = 3'd4;

  // Pixel masks
  localparam logic [31:0] MASK_ALPHA = 32'hFF00_0000;
  localparam logic [31:0] MASK_RGB   = 32'h00FF_FFFF;
  localparam logic [31:0] MASK_RB    = 32'h00FF_00FF;
  localparam logic [31:0] MASK_G     = 32'h0000_FF00;

  localparam logic [7:0] CHAN_MAX = 8'hFF;

  // Reciprocal of 255 scaled by 2^23, exact for 16-bit dividends
  localparam logic [31:0] RECIP_255   = 32'd32897;
  localparam int unsigned RECIP_SHIFT = 23;

  // Load enables of the first two pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

endpackage

@@ design/rpc_glyph_chan.sv @@
// One color channel of the glyph coverage blend: bg + (c - bg) * a / 255.
`timescale 1ns / 1ps

module rpc_glyph_chan (
  input  logic              clk,
  input  rpc_pkg::stage_en_t en,
  input  logic [7:0]        bg,
  input  logic [7:0]        color,
  input  logic [7:0]        cov,
  output logic [7:0]        chan_out
);

  logic signed [8:0]  diff;
  logic signed [17:0] prod_full;
  logic signed [16:0] prod_r;
  logic [7:0]         bg1_r;

  logic [15:0] mag;
  logic [31:0] recip_prod;
  logic        neg_r;
  logic [7:0]  quo_r;
  logic [7:0]  bg2_r;

  // Stage 1: signed difference times coverage
  assign diff      = $signed({1'b0, color}) - $signed({1'b0, bg});
  assign prod_full = diff * $signed({1'b0, cov});

  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod_r <= prod_full[16:0];
      bg1_r  <= bg;
    end
  end

  // Stage 2: divide magnitude by 255 through the reciprocal, keep the sign
  assign mag        = prod_r[16] ? 16'(-prod_r) : prod_r[15:0];
  assign recip_prod = {16'b0, mag} * rpc_pkg::RECIP_255;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      neg_r <= prod_r[16];
      quo_r <= recip_prod[rpc_pkg::RECIP_SHIFT +: 8];
      bg2_r <= bg1_r;
    end
  end

  // Add the truncated quotient back onto the background, low byte only
  assign chan_out = neg_r ? (bg2_r - quo_r) : (bg2_r + quo_r);

endmodule

@@ design/rpc_src_blend.sv @@
// Source-alpha blend of red/blue pair and green in packed 32-bit wraparound arithmetic.
`timescale 1ns / 1ps

module rpc_src_blend (
  input  logic              clk,
  input  rpc_pkg::stage_en_t en,
  input  logic [31:0]       dst,
  input  logic [31:0]       src,
  output logic [31:0]       rgb_out
);

  logic [31:0] d_rb, d_g, rb_mul, g_mul;
  logic [7:0]  sa;
  logic [31:0] rb_prod_r, g_prod_r, d_rb_r, d_g_r;
  logic [31:0] rb_r, g_r;

  // Stage 1: masked differences times source alpha, kept modulo 2^32
  assign sa     = src[31:24];
  assign d_rb   = dst & rpc_pkg::MASK_RB;
  assign d_g    = dst & rpc_pkg::MASK_G;
  assign rb_mul = ((src & rpc_pkg::MASK_RB) - d_rb) * {24'b0, sa};
  assign g_mul  = ((src & rpc_pkg::MASK_G) - d_g) * {24'b0, sa};

  always_ff @(posedge clk) begin
    if (en.s1) begin
      rb_prod_r <= rb_mul;
      g_prod_r  <= g_mul;
      d_rb_r    <= d_rb;
      d_g_r     <= d_g;
    end
  end

  // Stage 2: scale down, add back the destination, mask
  always_ff @(posedge clk) begin
    if (en.s2) begin
      rb_r <= (d_rb_r + {8'b0, rb_prod_r[31:8]}) & rpc_pkg::MASK_RB;
      g_r  <= (d_g_r + {8'b0, g_prod_r[31:8]}) & rpc_pkg::MASK_G;
    end
  end

  assign rgb_out = rb_r | g_r;

endmodule

@@ design/raster_pixel_combine_unit.sv @@
// Top level of the ARGB32 raster pixel combine unit: config, pipeline control, result select.
`timescale 1ns / 1ps

// Channel  Ports                                    Direction
// in       in_valid/in_ready, in_dst_pixel, in_src_value   pixel pair in
// out      out_valid/out_ready, out_pixel                   combined pixel out
// cfg      cfg_valid/cfg_ready, cfg_index, cfg_data         register write
//
// Three register stages; one item enters per cycle unless out_ready stalls the pipeline.
// A result passes stages 1 and 2 into the output register and leaves it when out_ready is high.
// The depth is set by the stage 1 multipliers and the stage 2 reciprocal multiply.
// Reset (rst_n low, synchronous) clears valid bits and the registers to mode 0,
// color 0. A stall at out_ready holds every occupied stage; bubbles close up.

module raster_pixel_combine_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [31:0]                    in_dst_pixel,
  input  logic [31:0]                    in_src_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [31:0]                    out_pixel,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);

  logic [2:0]  op_mode_r;
  logic [31:0] draw_color_r;

  logic v1_r, v2_r, v3_r;
  logic en3;
  rpc_pkg::stage_en_t en;

  logic [2:0]  mode1_r, mode2_r;
  logic [31:0] dst1_r, dst2_r, src1_r, src2_r;

  logic [7:0]  glyph_r, glyph_g, glyph_b;
  logic [31:0] blend_rgb;
  logic [31:0] res_nxt;
  logic [31:0] out_pixel_r;

  // Configuration registers; always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_mode_r    <= rpc_pkg::MODE_FILL;
      draw_color_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == rpc_pkg::REG_OP_MODE) begin
        op_mode_r <= cfg_data[2:0];
      end else if (cfg_index == rpc_pkg::REG_DRAW_COLOR) begin
        draw_color_r <= cfg_data;
      end
    end
  end

  // Advance a stage when it is empty or the next one moves
  assign en3      = !v3_r || out_ready;
  assign en.s2    = !v2_r || en3;
  assign en.s1    = !v1_r || en.s2;
  assign in_ready = en.s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en.s1) begin
        v1_r <= in_valid;
      end
      if (en.s2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  // Carry mode and pixels alongside the arithmetic lanes
  always_ff @(posedge clk) begin
    if (en.s1) begin
      mode1_r <= op_mode_r;
      dst1_r  <= in_dst_pixel;
      src1_r  <= in_src_value;
    end
    if (en.s2) begin
      mode2_r <= mode1_r;
      dst2_r  <= dst1_r;
      src2_r  <= src1_r;
    end
  end

  // Glyph coverage lanes, one per color channel
  rpc_glyph_chan u_glyph_r (
    .clk      (clk),
    .en       (en),
    .bg       (in_dst_pixel[23:16]),
    .color    (draw_color_r[23:16]),
    .cov      (in_src_value[7:0]),
    .chan_out (glyph_r)
  );

  rpc_glyph_chan u_glyph_g (
    .clk      (clk),
    .en       (en),
    .bg       (in_dst_pixel[15:8]),
    .color    (draw_color_r[15:8]),
    .cov      (in_src_value[7:0]),
    .chan_out (glyph_g)
  );

  rpc_glyph_chan u_glyph_b (
    .clk      (clk),
    .en       (en),
    .bg       (in_dst_pixel[7:0]),
    .color    (draw_color_r[7:0]),
    .cov      (in_src_value[7:0]),
    .chan_out (glyph_b)
  );

  // Source-alpha blend lane
  rpc_src_blend u_src_blend (
    .clk     (clk),
    .en      (en),
    .dst     (in_dst_pixel),
    .src     (in_src_value),
    .rgb_out (blend_rgb)
  );

  // Pick the result by mode, handling full and zero coverage or alpha
  always_comb begin
    case (mode2_r)
      rpc_pkg::MODE_FILL: begin
        res_nxt = draw_color_r;
      end
      rpc_pkg::MODE_INVERT: begin
        res_nxt = dst2_r ^ rpc_pkg::MASK_RGB;
      end
      rpc_pkg::MODE_GLYPH: begin
        if (src2_r[7:0] == rpc_pkg::CHAN_MAX) begin
          res_nxt = draw_color_r;
        end else if (src2_r[7:0] == 8'd0) begin
          res_nxt = dst2_r;
        end else begin
          res_nxt = {dst2_r[31:24], glyph_r, glyph_g, glyph_b};
        end
      end
      rpc_pkg::MODE_BLIT: begin
        res_nxt = src2_r;
      end
      rpc_pkg::MODE_BLEND: begin
        if (src2_r[31:24] == rpc_pkg::CHAN_MAX) begin
          res_nxt = (dst2_r & rpc_pkg::MASK_ALPHA) | (src2_r & rpc_pkg::MASK_RGB);
        end else if (src2_r[31:24] == 8'd0) begin
          res_nxt = dst2_r;
        end else begin
          res_nxt = (dst2_r & rpc_pkg::MASK_ALPHA) | blend_rgb;
        end
      end
      default: begin
        res_nxt = dst2_r;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en3) begin
      out_pixel_r <= res_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_pixel = out_pixel_r;

endmodule
